/* design/tgc_pkg.sv */
// Shared types and constants for the touch gesture classifier.
`default_nettype none
package tgc_pkg;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned CountWidth  = 2;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned DataWidth   = 32;

  typedef enum logic [2:0] {
    GESTURE_NONE   = 3'd0,
    GESTURE_SINGLE = 3'd1,
    GESTURE_DOUBLE = 3'd2,
    GESTURE_TRIPLE = 3'd3,
    GESTURE_LONG   = 3'd4
  } gesture_t;

  // Register index is taken from the word address bit.
  localparam logic REG_DETECT_PERIOD  = 1'b0;
  localparam logic REG_RELEASE_PERIOD = 1'b1;

  localparam logic [PeriodWidth-1:0] DetectPeriodReset  = 16'd1000;
  localparam logic [PeriodWidth-1:0] ReleasePeriodReset = 16'd500;

  localparam logic [CountWidth-1:0] CountMax = 2'd3;

  typedef struct packed {
    logic [PeriodWidth-1:0] detect_period_ms;
    logic [PeriodWidth-1:0] release_period_ms;
  } cfg_t;

  typedef struct packed {
    logic session_active;
    logic awaiting_release;
  } status_t;

endpackage
`default_nettype wire

/* design/tgc_if.sv */
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface tgc_sample_if;
  logic        valid;
  logic        ready;
  logic        pressed;
  logic [31:0] now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface tgc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface
`default_nettype wire

/* design/touch_gesture_classifier.sv */
// Top level of the touch gesture classifier: sample register, core and result register.
`default_nettype none
// Each accepted sample (pin level plus millisecond time) yields exactly one result,
// a gesture code that is nonzero only once per touch session, when the detection
// window after the first press has passed. Samples are accepted every cycle while
// the result register is not stalled; a sample is registered in the input register,
// classified against the session state when it advances and its result is loaded
// into the output register in that same cycle. The throughput is one sample per
// cycle while the result side does not stall. While the result register is stalled,
// one more sample is held in the input register before the sample channel deasserts
// ready. The detection and release periods are written over the configuration port
// at byte addresses 0 and 4; the user must write them only while the block is idle,
// which the block itself does not enforce.
module touch_gesture_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tgc_sample_if.sink                          sample,
  tgc_result_if.source                        result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tgc_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [tgc_pkg::DataWidth-1:0]  pwdata,
  output logic      [tgc_pkg::DataWidth-1:0]  prdata,
  output logic                                pready
);
  import tgc_pkg::*;

  cfg_t     cfg;
  status_t  status;
  gesture_t gesture_c;

  logic                 s1_valid;
  logic                 s1_pressed;
  logic [TimeWidth-1:0] s1_now_ms;
  logic                 out_valid;
  gesture_t             out_gesture;
  logic                 advance;

  tgc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .pressed (s1_pressed),
    .now_ms  (s1_now_ms),
    .cfg     (cfg),
    .gesture (gesture_c),
    .status  (status)
  );

  // The registered sample moves on whenever the result register is free or drains.
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_pressed <= sample.pressed;
      s1_now_ms  <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_gesture <= gesture_c;
    end
  end

  assign result.valid   = out_valid;
  assign result.gesture = out_gesture;

  // A reported gesture always leaves the session waiting for release.
  a_report_sets_wait: assert property (@(posedge clk) disable iff (rst)
    (advance && gesture_c != GESTURE_NONE) |=> status.awaiting_release)
    else $error("gesture reported without entering the release wait");

  // Waiting for release only happens inside an open session.
  a_wait_in_session: assert property (@(posedge clk) disable iff (rst)
    status.awaiting_release |-> status.session_active)
    else $error("release wait outside an active session");

  // A held sample is not lost while the result side stalls.
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_now_ms) && $stable(s1_pressed)))
    else $error("registered sample dropped during a stall");

endmodule
`default_nettype wire

/* design/tgc_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none
module tgc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tgc_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [tgc_pkg::DataWidth-1:0]  pwdata,
  output logic      [tgc_pkg::DataWidth-1:0]  prdata,
  output logic                                pready,
  output tgc_pkg::cfg_t                       cfg
);
  import tgc_pkg::*;

  cfg_t regs;
  logic wr_en;
  logic index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[2];
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detect_period_ms  <= DetectPeriodReset;
      regs.release_period_ms <= ReleasePeriodReset;
    end else if (wr_en) begin
      unique case (index)
        REG_DETECT_PERIOD:  regs.detect_period_ms  <= pwdata[PeriodWidth-1:0];
        REG_RELEASE_PERIOD: regs.release_period_ms <= pwdata[PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_DETECT_PERIOD:  prdata[PeriodWidth-1:0] = regs.detect_period_ms;
      REG_RELEASE_PERIOD: prdata[PeriodWidth-1:0] = regs.release_period_ms;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* design/tgc_core.sv */
// Session state and gesture classification for one sample per step.
`default_nettype none
module tgc_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic                           pressed,
  input  wire logic [tgc_pkg::TimeWidth-1:0]  now_ms,
  input  tgc_pkg::cfg_t                       cfg,
  output tgc_pkg::gesture_t                   gesture,
  output tgc_pkg::status_t                    status
);
  import tgc_pkg::*;

  logic                  prev_level, prev_level_next;
  logic                  session_active, session_active_next;
  logic [TimeWidth-1:0]  start_time, start_time_next;
  logic [TimeWidth-1:0]  release_time, release_time_next;
  logic [CountWidth-1:0] press_count, press_count_next;
  logic                  awaiting_release, awaiting_release_next;
  logic [TimeWidth-1:0]  since_start;
  logic [TimeWidth-1:0]  since_release;
  logic                  window_done;
  logic                  release_done;

  assign status.session_active   = session_active;
  assign status.awaiting_release = awaiting_release;

  always_comb begin
    prev_level_next       = pressed;
    session_active_next   = session_active;
    start_time_next       = start_time;
    release_time_next     = release_time;
    press_count_next      = press_count;
    awaiting_release_next = awaiting_release;
    gesture               = GESTURE_NONE;

    if (pressed != prev_level) begin
      if (pressed) begin
        if (press_count != CountMax) begin
          press_count_next = press_count + CountWidth'(1);
        end
        release_time_next = '0;
        if (!session_active) begin
          session_active_next = 1'b1;
          start_time_next     = now_ms;
        end
      end else begin
        release_time_next = now_ms;
      end
    end

    // The window and release checks see the times as updated by this sample.
    since_start   = now_ms - start_time_next;
    since_release = now_ms - release_time_next;
    window_done   = session_active_next &&
                    (since_start > TimeWidth'(cfg.detect_period_ms));
    release_done  = !pressed && (since_release > TimeWidth'(cfg.release_period_ms));

    if (window_done) begin
      if (!awaiting_release) begin
        awaiting_release_next = 1'b1;
        unique case (press_count_next)
          2'd1:    gesture = pressed ? GESTURE_LONG : GESTURE_SINGLE;
          2'd2:    gesture = GESTURE_DOUBLE;
          default: gesture = GESTURE_TRIPLE;
        endcase
      end else if (release_done) begin
        session_active_next   = 1'b0;
        start_time_next       = '0;
        release_time_next     = '0;
        press_count_next      = '0;
        awaiting_release_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level       <= 1'b0;
      session_active   <= 1'b0;
      start_time       <= '0;
      release_time     <= '0;
      press_count      <= '0;
      awaiting_release <= 1'b0;
    end else if (step) begin
      prev_level       <= prev_level_next;
      session_active   <= session_active_next;
      start_time       <= start_time_next;
      release_time     <= release_time_next;
      press_count      <= press_count_next;
      awaiting_release <= awaiting_release_next;
    end
  end

endmodule
`default_nettype wire

/* tb/touch_gesture_classifier_tb.sv */
// Self-checking testbench for the touch gesture classifier with its own gesture predictor.
`default_nettype none
module touch_gesture_classifier_tb;
  import tgc_pkg::*;

  localparam int unsigned PhaseItems = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 20000;

  localparam logic [AddrWidth-1:0] ADDR_DETECT  = {REG_DETECT_PERIOD, 2'b00};
  localparam logic [AddrWidth-1:0] ADDR_RELEASE = {REG_RELEASE_PERIOD, 2'b00};

  typedef struct {
    logic        pressed;
    logic [31:0] now_ms;
    logic        typed;
    gesture_t    gesture;
  } sample_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  tgc_sample_if sample_ch ();
  tgc_result_if result_ch ();

  touch_gesture_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state and its copy of the two period registers.
  logic                   lvl_q;
  logic                   active_q;
  logic [TimeWidth-1:0]   start_q;
  logic [TimeWidth-1:0]   rel_q;
  logic [CountWidth-1:0]  count_q;
  logic                   await_q;
  logic [PeriodWidth-1:0] detect_cfg;
  logic [PeriodWidth-1:0] release_cfg;

  sample_row_t stim_q[$];
  gesture_t    gesture_q[$];
  int unsigned errors;
  logic [31:0] touch_ms;

  // Driver-side tags that travel with the request on the sample channel.
  logic        drv_typed;
  gesture_t    drv_gesture;
  logic        sample_fired;
  int unsigned burst_left;
  int unsigned gap_left;

  int unsigned hold_req;
  int unsigned hold_taken;
  int unsigned hold_left;
  rx_mode_t    rx_mode;
  int unsigned mode_left;
  int unsigned pat_cnt;
  int unsigned idle_cycles;

  gesture_t    predicted;
  gesture_t    wanted;

  // Directed rows run with the reset periods (1000 ms window, 500 ms release).
  sample_row_t dir_table [28] = '{
    '{1'b0, 32'd0,          1'b1, GESTURE_NONE},
    '{1'b1, 32'd10,         1'b1, GESTURE_NONE},
    '{1'b1, 32'd1010,       1'b1, GESTURE_NONE},
    '{1'b1, 32'd1011,       1'b1, GESTURE_LONG},
    '{1'b0, 32'd6000,       1'b1, GESTURE_NONE},
    '{1'b0, 32'd6501,       1'b1, GESTURE_NONE},
    '{1'b1, 32'd7000,       1'b1, GESTURE_NONE},
    '{1'b0, 32'd7100,       1'b1, GESTURE_NONE},
    '{1'b0, 32'd8001,       1'b1, GESTURE_SINGLE},
    '{1'b0, 32'd8601,       1'b0, GESTURE_NONE},
    '{1'b1, 32'd9000,       1'b0, GESTURE_NONE},
    '{1'b0, 32'd9050,       1'b0, GESTURE_NONE},
    '{1'b1, 32'd9100,       1'b0, GESTURE_NONE},
    '{1'b0, 32'd9150,       1'b0, GESTURE_NONE},
    '{1'b0, 32'd10001,      1'b1, GESTURE_DOUBLE},
    '{1'b0, 32'd10600,      1'b0, GESTURE_NONE},
    '{1'b1, 32'd11000,      1'b0, GESTURE_NONE},
    '{1'b0, 32'd11010,      1'b0, GESTURE_NONE},
    '{1'b1, 32'd11020,      1'b0, GESTURE_NONE},
    '{1'b0, 32'd11030,      1'b0, GESTURE_NONE},
    '{1'b1, 32'd11040,      1'b0, GESTURE_NONE},
    '{1'b0, 32'd11050,      1'b0, GESTURE_NONE},
    '{1'b1, 32'd11060,      1'b0, GESTURE_NONE},
    '{1'b1, 32'd12001,      1'b1, GESTURE_TRIPLE},
    '{1'b0, 32'hFFFF_FFFF,  1'b0, GESTURE_NONE},
    '{1'b0, 32'h0000_01F4,  1'b0, GESTURE_NONE},
    '{1'b1, 32'hFFFF_FF00,  1'b0, GESTURE_NONE},
    '{1'b1, 32'h0000_02E9,  1'b1, GESTURE_LONG}
  };

  function automatic gesture_t classify_sample(input logic lvl, input logic [31:0] now);
    gesture_t       g;
    logic [31:0]    held_for;
    logic [31:0]    released_for;
    g = GESTURE_NONE;
    if (lvl != lvl_q) begin
      if (lvl) begin
        if (count_q != CountMax) count_q = count_q + 1'b1;
        rel_q = '0;
        if (!active_q) begin
          active_q = 1'b1;
          start_q  = now;
        end
      end else begin
        rel_q = now;
      end
      lvl_q = lvl;
    end
    held_for     = now - start_q;
    released_for = now - rel_q;
    if (active_q && held_for > {16'h0, detect_cfg}) begin
      if (!await_q) begin
        await_q = 1'b1;
        case (count_q)
          2'd1:    g = lvl ? GESTURE_LONG : GESTURE_SINGLE;
          2'd2:    g = GESTURE_DOUBLE;
          default: g = GESTURE_TRIPLE;
        endcase
      end else if (!lvl && released_for > {16'h0, release_cfg}) begin
        active_q = 1'b0;
        start_q  = '0;
        rel_q    = '0;
        count_q  = '0;
        await_q  = 1'b0;
      end
    end
    return g;
  endfunction

  function automatic void queue_sample(input logic p, input logic [31:0] t);
    stim_q.push_back('{p, t, 1'b0, GESTURE_NONE});
  endfunction

  // One touch session: a few clicks inside the window, a sample near the window edge,
  // then released samples around the end of the release period.
  function automatic void queue_session(input int unsigned det, input int unsigned rel);
    int unsigned clicks;
    int unsigned span;
    logic        hold;
    logic [31:0] t0;
    logic [31:0] tr;
    clicks = $urandom_range(1, 4);
    hold   = (clicks == 1) && ($urandom_range(0, 1) == 1);
    span   = det / (2 * clicks) + 1;
    touch_ms = touch_ms + $urandom_range(1, 50);
    t0 = touch_ms;
    tr = touch_ms;
    for (int k = 0; k < clicks; k++) begin
      queue_sample(1'b1, touch_ms);
      repeat ($urandom_range(0, 2)) begin
        touch_ms = touch_ms + $urandom_range(0, span);
        queue_sample(1'b1, touch_ms);
      end
      if (!(hold && k == clicks - 1)) begin
        touch_ms = touch_ms + $urandom_range(1, span);
        queue_sample(1'b0, touch_ms);
        tr = touch_ms;
      end
      touch_ms = touch_ms + $urandom_range(1, span);
    end
    if (touch_ms - t0 <= det) touch_ms = t0 + det + $urandom_range(0, 2);
    queue_sample(hold, touch_ms);
    if (hold) begin
      touch_ms = touch_ms + $urandom_range(1, span);
      queue_sample(1'b0, touch_ms);
      tr = touch_ms;
    end
    touch_ms = tr + rel + $urandom_range(0, 2);
    queue_sample(1'b0, touch_ms);
    repeat ($urandom_range(0, 2)) begin
      touch_ms = touch_ms + $urandom_range(0, rel / 2 + 2);
      queue_sample(1'b0, touch_ms);
    end
  endfunction

  task automatic write_period(input logic [AddrWidth-1:0] addr, input logic [PeriodWidth-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(DataWidth-PeriodWidth){1'b0}}, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Read the register straight back.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[PeriodWidth-1:0] !== val) begin
      $display("%0t register %0d readback mismatch: expected %0d, actual %0d",
               $time, addr, val, prdata[PeriodWidth-1:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (stim_q.size() != 0 || sample_ch.valid || gesture_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!sample_ch.valid || sample_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_ch.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        sample_row_t row;
        row = stim_q.pop_front();
        sample_ch.valid   <= 1'b1;
        sample_ch.pressed <= row.pressed;
        sample_ch.now_ms  <= row.now_ms;
        drv_typed         <= row.typed;
        drv_gesture       <= row.gesture;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall patterns, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst) begin
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_taken != hold_req) begin
        hold_taken = hold_req;
        hold_left  = HoldCycles;
        result_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:  result_ch.ready <= 1'b1;
          RX_COIN:  result_ch.ready <= 1'($urandom_range(0, 1));
          default:  result_ch.ready <= (pat_cnt % 5) != 4;
        endcase
      end
    end
  end

  // Prediction on every accepted sample request, checking on every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      sample_fired <= 1'b0;
    end else begin
      sample_fired <= sample_ch.valid && sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready) begin
        predicted = classify_sample(sample_ch.pressed, sample_ch.now_ms);
        gesture_q.push_back(drv_typed ? drv_gesture : predicted);
      end
      if (result_ch.valid && result_ch.ready) begin
        if (gesture_q.size() == 0) begin
          $display("%0t unexpected result: expected nothing, actual %0d",
                   $time, result_ch.gesture);
          errors++;
        end else begin
          wanted = gesture_q.pop_front();
          if (result_ch.gesture !== wanted) begin
            $display("%0t gesture mismatch: expected %0d, actual %0d",
                     $time, wanted, result_ch.gesture);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned det_list [6];
    int unsigned rel_list [6];
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sample_ch.valid   = 1'b0;
    sample_ch.pressed = 1'b0;
    sample_ch.now_ms  = '0;
    result_ch.ready   = 1'b0;
    drv_typed         = 1'b0;
    drv_gesture       = GESTURE_NONE;
    errors            = 0;
    burst_left        = 0;
    gap_left          = 0;
    hold_req          = 0;
    hold_taken        = 0;
    hold_left         = 0;
    rx_mode           = RX_OPEN;
    mode_left         = 0;
    pat_cnt           = 0;
    idle_cycles       = 0;
    lvl_q             = 1'b0;
    active_q          = 1'b0;
    start_q           = '0;
    rel_q             = '0;
    count_q           = '0;
    await_q           = 1'b0;
    detect_cfg        = DetectPeriodReset;
    release_cfg       = ReleasePeriodReset;

    det_list = '{0, 65535, $urandom_range(0, 65535), 3, $urandom_range(0, 200), 1000};
    rel_list = '{0, 65535, $urandom_range(0, 65535), 1, $urandom_range(0, 200), 500};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) stim_q.push_back(dir_table[i]);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_period(ADDR_DETECT, det_list[ph][PeriodWidth-1:0]);
      write_period(ADDR_RELEASE, rel_list[ph][PeriodWidth-1:0]);
      detect_cfg  = det_list[ph][PeriodWidth-1:0];
      release_cfg = rel_list[ph][PeriodWidth-1:0];
      touch_ms    = $urandom();
      while (stim_q.size() < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: arbitrary levels and times that break up any session in progress.
          repeat ($urandom_range(1, 3)) queue_sample(1'($urandom_range(0, 1)), $urandom());
        end else begin
          queue_session(detect_cfg, release_cfg);
        end
      end
      // Stall the result side long enough that the block backs up into the sender.
      if (ph == 2) hold_req++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
